// ----- src/spl_pkg.sv -----
`timescale 1ns / 1ps

package spl_pkg;

    typedef logic [1:0] t_op;
    typedef logic [2:0] t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_DELETE = 2'd1;
    localparam t_op OP_FIND   = 2'd2;
    localparam t_op OP_LIST   = 2'd3;

    localparam t_status ST_DONE     = 3'd0;
    localparam t_status ST_FULL     = 3'd1;
    localparam t_status ST_EMPTY    = 3'd2;
    localparam t_status ST_NOTFOUND = 3'd3;
    localparam t_status ST_ENTRY    = 3'd4;

endpackage

// ----- src/sorted_priority_list_unit.sv -----
`timescale 1ns / 1ps
// path: an input beat passes the front register, the queue and the EXEC state to the result register
// sequencer: insert, delete and find go from IDLE to EXEC; the back end takes a request only in IDLE
// list emits one beat per stored entry from EXEC then LIST (the cell chain rotates one slot per beat)
// reset: synchronous active low, clears the entry count, the queue and all valid flags
// table contents are not cleared; there is no clearing pass

module sorted_priority_list_unit #(
    parameter int DEPTH     = 16,
    parameter int TAG_BITS  = 32,
    parameter int PRIO_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tag, priority_req
    input  logic [((TAG_BITS+PRIO_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // kind
    input  logic [1:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // out_tag, out_priority
    output logic [((TAG_BITS+PRIO_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // status
    output spl_pkg::t_status     o_m_axis_tuser,
    output logic                 o_m_axis_tlast
);
    import spl_pkg::*;

    localparam int FB = TAG_BITS + PRIO_BITS;
    localparam int DW = ((FB + 7) / 8) * 8;
    localparam int QW = 2 + FB;

    logic                        w_f_valid;
    logic                        w_f_ready;
    t_op                         w_f_op;
    logic [TAG_BITS-1:0]         w_f_tag;
    logic signed [PRIO_BITS-1:0] w_f_prio;
    logic [QW-1:0]               w_q_in;
    logic [QW-1:0]               w_q_out;
    logic                        w_q_valid;
    logic                        w_q_ready;
    logic [TAG_BITS-1:0]         w_o_tag;
    logic signed [PRIO_BITS-1:0] w_o_prio;

    spl_front #(
        .TAG_BITS  (TAG_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_kind  (i_s_axis_tuser),
        .i_tag   (i_s_axis_tdata[TAG_BITS-1:0]),
        .i_prio  (i_s_axis_tdata[FB-1:TAG_BITS]),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_op    (w_f_op),
        .o_tag   (w_f_tag),
        .o_prio  (w_f_prio)
    );

    assign w_q_in = {w_f_op, w_f_prio, w_f_tag};

    spl_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_q_in),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_out)
    );

    spl_back #(
        .DEPTH     (DEPTH),
        .TAG_BITS  (TAG_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_ready),
        .i_op     (w_q_out[QW-1:FB]),
        .i_tag    (w_q_out[TAG_BITS-1:0]),
        .i_prio   (w_q_out[FB-1:TAG_BITS]),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_status (o_m_axis_tuser),
        .o_tag    (w_o_tag),
        .o_prio   (w_o_prio),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = DW'({w_o_prio, w_o_tag});

    a_single_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_ENTRY)) |-> o_m_axis_tlast)
        else $error("non-list result without last");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && ((o_m_axis_tuser == ST_FULL) || (o_m_axis_tuser == ST_EMPTY)
        || (o_m_axis_tuser == ST_NOTFOUND))) |-> (o_m_axis_tdata == '0))
        else $error("refusal carries data");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result beat right after reset");

endmodule

// ----- src/spl_front.sv -----
`timescale 1ns / 1ps

module spl_front #(
    parameter int TAG_BITS  = 32,
    parameter int PRIO_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_kind,
    input  logic [TAG_BITS-1:0]         i_tag,
    input  logic signed [PRIO_BITS-1:0] i_prio,
    output logic                        o_valid,
    input  logic                        i_ready,
    output spl_pkg::t_op                o_op,
    output logic [TAG_BITS-1:0]         o_tag,
    output logic signed [PRIO_BITS-1:0] o_prio
);
    import spl_pkg::*;

    logic                        r_valid;
    t_op                         r_op;
    logic [TAG_BITS-1:0]         r_tag;
    logic signed [PRIO_BITS-1:0] r_prio;
    t_op                         n_op;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        unique case (i_kind)
            OP_INSERT: n_op = OP_INSERT;
            OP_DELETE: n_op = OP_DELETE;
            OP_FIND:   n_op = OP_FIND;
            default:   n_op = OP_LIST;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op   <= n_op;
            r_tag  <= i_tag;
            r_prio <= i_prio;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_tag   = r_tag;
    assign o_prio  = r_prio;

endmodule

// ----- src/spl_queue.sv -----
`timescale 1ns / 1ps

module spl_queue #(
    parameter int WIDTH = 50
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- src/spl_back.sv -----
`timescale 1ns / 1ps

module spl_back #(
    parameter int DEPTH     = 16,
    parameter int TAG_BITS  = 32,
    parameter int PRIO_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  spl_pkg::t_op                i_op,
    input  logic [TAG_BITS-1:0]         i_tag,
    input  logic signed [PRIO_BITS-1:0] i_prio,
    output logic                        o_valid,
    input  logic                        i_ready,
    output spl_pkg::t_status            o_status,
    output logic [TAG_BITS-1:0]         o_tag,
    output logic signed [PRIO_BITS-1:0] o_prio,
    output logic                        o_last
);
    import spl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0]                  r_state;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_left;
    t_op                         r_op;
    logic [TAG_BITS-1:0]         r_tag_q;
    logic signed [PRIO_BITS-1:0] r_prio_q;
    logic [DEPTH-1:0]            r_h;
    logic [DEPTH-1:0]            r_dm;
    logic [DEPTH-1:0]            r_fm;

    logic [TAG_BITS-1:0]         r_tag  [DEPTH];
    logic signed [PRIO_BITS-1:0] r_prio [DEPTH];

    logic                        r_ov;
    t_status                     r_st;
    logic [TAG_BITS-1:0]         r_otag;
    logic signed [PRIO_BITS-1:0] r_oprio;
    logic                        r_olast;

    logic                        w_pop;
    logic                        w_free;
    logic                        w_exec;
    logic                        w_list;
    logic                        w_full;
    logic                        w_empty;
    logic                        w_ins;
    logic                        w_del;
    logic                        w_rot;
    logic [DEPTH-1:0]            w_hp;
    logic [DEPTH-1:0]            w_d;
    logic [DEPTH-1:0]            w_f1;
    logic [TAG_BITS-1:0]         w_ftag;
    logic signed [PRIO_BITS-1:0] w_fprio;

    assign o_ready = (r_state == S_IDLE);
    assign w_pop   = i_valid && o_ready;
    assign w_free  = !r_ov || i_ready;
    assign w_exec  = (r_state == S_EXEC) && w_free;
    assign w_list  = (r_state == S_LIST) && w_free;
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_ins   = w_exec && (r_op == OP_INSERT) && !w_full;
    assign w_del   = w_exec && (r_op == OP_DELETE) && !w_empty && (|r_dm);
    assign w_rot   = (w_exec && (r_op == OP_LIST) && !w_empty) || w_list;

    // thermometers of slots past the insert point and from the first tag match up, first priority-match mask
    assign w_hp = {r_h[DEPTH-2:0], 1'b0};
    assign w_d  = r_dm | (~r_dm + DEPTH'(1));
    assign w_f1 = r_fm & (~r_fm + DEPTH'(1));

    always_comb begin
        w_ftag  = '0;
        w_fprio = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_ftag  = w_ftag  | (r_tag[k]  & {TAG_BITS{w_f1[k]}});
            w_fprio = w_fprio | (r_prio[k] & {PRIO_BITS{w_f1[k]}});
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [TAG_BITS-1:0]         w_prev_tag;
        logic signed [PRIO_BITS-1:0] w_prev_prio;
        logic [TAG_BITS-1:0]         w_next_tag;
        logic signed [PRIO_BITS-1:0] w_next_prio;
        logic                        w_in_use;

        if (i == 0) begin : g_first
            assign w_prev_tag  = r_tag_q;
            assign w_prev_prio = r_prio_q;
        end else begin : g_mid
            assign w_prev_tag  = r_tag[i-1];
            assign w_prev_prio = r_prio[i-1];
        end
        if (i == DEPTH - 1) begin : g_top
            assign w_next_tag  = r_tag[i];
            assign w_next_prio = r_prio[i];
        end else begin : g_low
            assign w_next_tag  = r_tag[i+1];
            assign w_next_prio = r_prio[i+1];
        end

        assign w_in_use = (CW'(i) < r_count);

        always_ff @(posedge i_clk) begin
            if (w_pop) begin
                r_h[i]  <= !w_in_use || (r_prio[i] > i_prio);
                r_dm[i] <= w_in_use && (r_tag[i] == i_tag);
                r_fm[i] <= w_in_use && (r_prio[i] == i_prio);
            end
        end

        always_ff @(posedge i_clk) begin
            priority if (w_ins && r_h[i]) begin
                if (!w_hp[i]) begin
                    r_tag[i]  <= r_tag_q;
                    r_prio[i] <= r_prio_q;
                end else begin
                    r_tag[i]  <= w_prev_tag;
                    r_prio[i] <= w_prev_prio;
                end
            end else if (w_del && w_d[i]) begin
                r_tag[i]  <= w_next_tag;
                r_prio[i] <= w_next_prio;
            end else if (w_rot && (CW'(i + 1) < r_count)) begin
                r_tag[i]  <= w_next_tag;
                r_prio[i] <= w_next_prio;
            end else if (w_rot && (CW'(i + 1) == r_count)) begin
                r_tag[i]  <= r_tag[0];
                r_prio[i] <= r_prio[0];
            end else begin
                r_tag[i]  <= r_tag[i];
                r_prio[i] <= r_prio[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_op     <= i_op;
            r_tag_q  <= i_tag;
            r_prio_q <= i_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_free) begin
                r_ov <= w_exec || w_list;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_free) begin
                        if (w_ins) begin
                            r_count <= r_count + CW'(1);
                        end
                        if (w_del) begin
                            r_count <= r_count - CW'(1);
                        end
                        if ((r_op == OP_LIST) && !w_empty) begin
                            r_left <= r_count - CW'(1);
                        end
                        if ((r_op == OP_LIST) && !w_empty && (r_count != CW'(1))) begin
                            r_state <= S_LIST;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_LIST: begin
                    if (w_free) begin
                        r_left <= r_left - CW'(1);
                        if (r_left == CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            priority if (r_op == OP_INSERT) begin
                r_st    <= w_full ? ST_FULL : ST_DONE;
                r_otag  <= '0;
                r_oprio <= '0;
                r_olast <= 1'b1;
            end else if (w_empty) begin
                r_st    <= ST_EMPTY;
                r_otag  <= '0;
                r_oprio <= '0;
                r_olast <= 1'b1;
            end else if (r_op == OP_DELETE) begin
                r_st    <= (|r_dm) ? ST_DONE : ST_NOTFOUND;
                r_otag  <= '0;
                r_oprio <= '0;
                r_olast <= 1'b1;
            end else if (r_op == OP_FIND) begin
                r_st    <= (|r_fm) ? ST_DONE : ST_NOTFOUND;
                r_otag  <= w_ftag;
                r_oprio <= w_fprio;
                r_olast <= 1'b1;
            end else begin
                r_st    <= ST_ENTRY;
                r_otag  <= r_tag[0];
                r_oprio <= r_prio[0];
                r_olast <= (r_count == CW'(1));
            end
        end else if (w_list) begin
            r_st    <= ST_ENTRY;
            r_otag  <= r_tag[0];
            r_oprio <= r_prio[0];
            r_olast <= (r_left == CW'(1));
        end
    end

    assign o_valid  = r_ov;
    assign o_status = r_st;
    assign o_tag    = r_otag;
    assign o_prio   = r_oprio;
    assign o_last   = r_olast;

endmodule
